@@ hw/rtl/wrt_pkg.sv @@
`timescale 1ns / 1ps

package wrt_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int COORD_BITS_DEF = 24;

	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int TOL_W    = 24;
	localparam int LEN_W    = 40;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(2560);
	localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_CHECK  = 2'd1,
		CMD_REWIND = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NONE = 2'd2;

endpackage

@@ hw/rtl/wrt_ram.sv @@
`timescale 1ns / 1ps

module wrt_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/wrt_dist.sv @@
`timescale 1ns / 1ps

module wrt_dist #(
	parameter int COORD_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid,
	input  logic signed [COORD_BITS-1:0]   a_x,
	input  logic signed [COORD_BITS-1:0]   a_y,
	input  logic signed [COORD_BITS-1:0]   a_z,
	input  logic signed [COORD_BITS-1:0]   b_x,
	input  logic signed [COORD_BITS-1:0]   b_y,
	input  logic signed [COORD_BITS-1:0]   b_z,
	output logic                           dist_valid,
	output logic [2*COORD_BITS+3:0]        dist_sq
);

	localparam int DW  = COORD_BITS + 1;
	localparam int PW  = 2 * DW;
	localparam int SQW = PW + 2;

	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic [PW-1:0]        sqx_s2, sqy_s2, sqz_s2;
	logic [SQW-1:0]       sum_s3;
	logic                 v_s1, v_s2, v_s3;
	logic signed [PW-1:0] px, py, pz;

	// products of signed differences are never negative
	always_comb begin
		px = dx_s1 * dx_s1;
		py = dy_s1 * dy_s1;
		pz = dz_s1 * dz_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= {a_x[COORD_BITS-1], a_x} - {b_x[COORD_BITS-1], b_x};
		dy_s1  <= {a_y[COORD_BITS-1], a_y} - {b_y[COORD_BITS-1], b_y};
		dz_s1  <= {a_z[COORD_BITS-1], a_z} - {b_z[COORD_BITS-1], b_z};
		sqx_s2 <= px;
		sqy_s2 <= py;
		sqz_s2 <= pz;
		sum_s3 <= SQW'(sqx_s2) + SQW'(sqy_s2) + SQW'(sqz_s2);
	end

	assign dist_valid = v_s3;
	assign dist_sq    = sum_s3;

endmodule

@@ hw/rtl/wrt_sqrt.sv @@
`timescale 1ns / 1ps

module wrt_sqrt #(
	parameter int SQ_W = 52
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   n,
	output logic              done,
	output logic [SQ_W/2-1:0] root
);

	localparam int RES_W = SQ_W / 2;
	localparam int CNT_W = $clog2(RES_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SQ_W-1:0]   n_q;
	logic [RES_W:0]    rem_q;
	logic [RES_W-1:0]  root_q;
	logic [RES_W+2:0]  rem_sh;
	logic [RES_W+2:0]  trial;
	logic [RES_W+2:0]  diff;
	logic              take;

	// one result bit per cycle, two radicand bits brought down each step
	always_comb begin
		rem_sh = {rem_q, n_q[SQ_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		diff   = rem_sh - trial;
		take   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			n_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RES_W);
				n_q    <= n;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				n_q    <= {n_q[SQ_W-3:0], 2'b00};
				rem_q  <= take ? diff[RES_W:0] : rem_sh[RES_W:0];
				root_q <= {root_q[RES_W-2:0], take};
				cnt_q  <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ hw/rtl/waypoint_route_tracker.sv @@
`timescale 1ns / 1ps

// Waypoint route tracker. A request is taken when start is high and busy is low:
// command, pos_x, pos_y, pos_z. Commands: append a waypoint, check a position
// against the current waypoint, rewind the index, clear the route.
// Exactly one result per request: done is high for one cycle with status,
// reached, current_index, point_count, path_length and target_x/y/z valid in
// that cycle. The receiver cannot stall; results must be taken when shown.
// One request at a time; busy stays high until the result cycle.
// Path from the accepting edge to done: decide, target read, output for rewind,
// clear, a rejected append or a check with no waypoint left; decide, write,
// target read, output for the first append of a route; decide, wait, distance,
// target read, output for a check; decide, wait, distance, square root, write,
// target read, output for any other append (radix-2 root, one bit per cycle).
// Waypoints live in a single one-read one-write memory; every request ends
// with a read of the current waypoint for the target outputs.
// Tolerance is written through cfg_we / cfg_wdata; the user must write it while
// the block is idle; the block does not enforce it. Reset clears the route, the
// index and path length (not the waypoint memory) and loads a tolerance of 2560.

module waypoint_route_tracker #(
	parameter int MAX_POINTS = wrt_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = wrt_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [wrt_pkg::CMD_W-1:0]              command,
	input  logic signed [COORD_BITS-1:0]           pos_x,
	input  logic signed [COORD_BITS-1:0]           pos_y,
	input  logic signed [COORD_BITS-1:0]           pos_z,
	input  logic                                   cfg_we,
	input  logic [wrt_pkg::TOL_W-1:0]              cfg_wdata,
	output logic                                   done,
	output logic [wrt_pkg::STATUS_W-1:0]           status,
	output logic                                   reached,
	output logic [$clog2(MAX_POINTS+1)-1:0]        current_index,
	output logic [$clog2(MAX_POINTS+1)-1:0]        point_count,
	output logic [wrt_pkg::LEN_W-1:0]              path_length,
	output logic signed [COORD_BITS-1:0]           target_x,
	output logic signed [COORD_BITS-1:0]           target_y,
	output logic signed [COORD_BITS-1:0]           target_z
);

	import wrt_pkg::*;

	localparam int IDX_W  = $clog2(MAX_POINTS + 1);
	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int WP_W   = 3 * COORD_BITS;
	localparam int SQ_W   = 2 * COORD_BITS + 4;
	localparam int RES_W  = SQ_W / 2;
	localparam int TSQ_W  = 2 * TOL_W;
	localparam int CMP_W  = (SQ_W > TSQ_W) ? SQ_W : TSQ_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_WAIT,
		S_DIST,
		S_SQRT,
		S_WRITE,
		S_TGT,
		S_OUT
	} state_t;

	state_t                      state_q;
	cmd_t                        cmd_q;
	logic signed [COORD_BITS-1:0] x_q, y_q, z_q;
	logic [IDX_W-1:0]            count_q;
	logic [IDX_W-1:0]            tgt_q;
	logic [LEN_W-1:0]            len_q;
	logic [TOL_W-1:0]            tol_q;
	logic [TSQ_W-1:0]            tolsq_q;

	logic                        ram_we;
	logic                        ram_re;
	logic [ADDR_W-1:0]           ram_raddr;
	logic [WP_W-1:0]             ram_rdata;

	logic                        dist_valid;
	logic [SQ_W-1:0]             dist_sq;
	logic                        sqrt_start;
	logic                        sqrt_done;
	logic [RES_W-1:0]            sqrt_root;
	logic [LEN_W:0]              len_sum;
	logic                        full;

	assign busy = (state_q != S_IDLE);
	assign full = (count_q >= IDX_W'(MAX_POINTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_DECIDE: begin
				if (cmd_q == CMD_APPEND && !full && count_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = ADDR_W'(count_q - IDX_W'(1));
				end else if (cmd_q == CMD_CHECK && tgt_q < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = ADDR_W'(tgt_q);
				end
			end
			S_TGT: begin
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(tgt_q);
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	assign ram_we     = (state_q == S_WRITE);
	assign sqrt_start = (state_q == S_DIST) && dist_valid && (cmd_q == CMD_APPEND);
	assign len_sum    = {1'b0, len_q} + (LEN_W + 1)'(sqrt_root);

	wrt_ram #(
		.WIDTH (WP_W),
		.DEPTH (MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(count_q)),
		.wdata ({x_q, y_q, z_q}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wrt_dist #(
		.COORD_BITS (COORD_BITS)
	) u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (state_q == S_WAIT),
		.a_x        (x_q),
		.a_y        (y_q),
		.a_z        (z_q),
		.b_x        (ram_rdata[WP_W-1 -: COORD_BITS]),
		.b_y        (ram_rdata[2*COORD_BITS-1 -: COORD_BITS]),
		.b_z        (ram_rdata[COORD_BITS-1:0]),
		.dist_valid (dist_valid),
		.dist_sq    (dist_sq)
	);

	wrt_sqrt #(
		.SQ_W (SQ_W)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.n      (dist_sq),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= CMD_APPEND;
			x_q           <= '0;
			y_q           <= '0;
			z_q           <= '0;
			count_q       <= '0;
			tgt_q         <= '0;
			len_q         <= '0;
			tolsq_q       <= '0;
			done          <= 1'b0;
			status        <= STAT_OK;
			reached       <= 1'b0;
			current_index <= '0;
			point_count   <= '0;
			path_length   <= '0;
			target_x      <= '0;
			target_y      <= '0;
			target_z      <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd_t'(command);
						x_q     <= pos_x;
						y_q     <= pos_y;
						z_q     <= pos_z;
						status  <= STAT_OK;
						reached <= 1'b0;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					tolsq_q <= tol_q * tol_q;
					unique case (cmd_q)
						CMD_APPEND: begin
							if (full) begin
								status  <= STAT_FULL;
								state_q <= S_TGT;
							end else if (count_q == '0) begin
								// first waypoint adds no length
								state_q <= S_WRITE;
							end else begin
								state_q <= S_WAIT;
							end
						end
						CMD_CHECK: begin
							if (tgt_q >= count_q) begin
								status  <= STAT_NONE;
								state_q <= S_TGT;
							end else begin
								state_q <= S_WAIT;
							end
						end
						CMD_REWIND: begin
							tgt_q   <= '0;
							state_q <= S_TGT;
						end
						CMD_CLEAR: begin
							count_q <= '0;
							tgt_q   <= '0;
							len_q   <= '0;
							state_q <= S_TGT;
						end
					endcase
				end
				S_WAIT: begin
					state_q <= S_DIST;
				end
				S_DIST: begin
					if (dist_valid) begin
						if (cmd_q == CMD_APPEND) begin
							state_q <= S_SQRT;
						end else begin
							// strictly inside the radius
							if (CMP_W'(dist_sq) < CMP_W'(tolsq_q)) begin
								tgt_q   <= tgt_q + IDX_W'(1);
								reached <= 1'b1;
							end
							state_q <= S_TGT;
						end
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						len_q   <= (len_sum >= {1'b0, LEN_MAX}) ? LEN_MAX : len_sum[LEN_W-1:0];
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					count_q <= count_q + IDX_W'(1);
					state_q <= S_TGT;
				end
				S_TGT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					done          <= 1'b1;
					current_index <= tgt_q;
					point_count   <= count_q;
					path_length   <= len_q;
					if (tgt_q < count_q) begin
						target_x <= ram_rdata[WP_W-1 -: COORD_BITS];
						target_y <= ram_rdata[2*COORD_BITS-1 -: COORD_BITS];
						target_z <= ram_rdata[COORD_BITS-1:0];
					end else begin
						target_x <= '0;
						target_y <= '0;
						target_z <= '0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a request is still in flight");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> current_index <= point_count)
		else $error("current index beyond stored route");

	a_reached_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && reached |-> status == STAT_OK)
		else $error("reached reported with error status");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted request did not start work");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import wrt_pkg::*;

	localparam int COORD_W = COORD_BITS_DEF;
	localparam int IDX_W = $clog2(MAX_POINTS_DEF + 1);
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef struct packed {
		cmd_t   cmd;
		point_t pos;
	} route_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                reached;
		logic [IDX_W-1:0]    index;
		logic [IDX_W-1:0]    count;
		logic [LEN_W-1:0]    length;
		point_t              target;
	} route_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [CMD_W-1:0] command = '0;
	logic signed [COORD_W-1:0] pos_x = '0;
	logic signed [COORD_W-1:0] pos_y = '0;
	logic signed [COORD_W-1:0] pos_z = '0;
	logic cfg_we = 1'b0;
	logic [TOL_W-1:0] cfg_wdata = '0;
	logic done;
	logic [STATUS_W-1:0] status;
	logic reached;
	logic [IDX_W-1:0] current_index;
	logic [IDX_W-1:0] point_count;
	logic [LEN_W-1:0] path_length;
	logic signed [COORD_W-1:0] target_x;
	logic signed [COORD_W-1:0] target_y;
	logic signed [COORD_W-1:0] target_z;

	route_req_t pending_reqs[$];
	route_report_t reports_due[$];
	point_t planned_route[$];
	int planned = 0;
	logic [TOL_W-1:0] plan_tol = TOL_RESET;

	// tracker state as the checker sees it
	point_t stored_route[MAX_POINTS_DEF];
	int model_count = 0;
	int model_index = 0;
	logic [63:0] model_len = '0;
	logic [TOL_W-1:0] model_tol = TOL_RESET;

	int mismatch_count = 0;
	int stall_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;

	waypoint_route_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.status(status),
		.reached(reached),
		.current_index(current_index),
		.point_count(point_count),
		.path_length(path_length),
		.target_x(target_x),
		.target_y(target_y),
		.target_z(target_z)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] sq_dist(input point_t a, input point_t b);
		longint dx, dy, dz;
		dx = longint'($signed(a.x)) - longint'($signed(b.x));
		dy = longint'($signed(a.y)) - longint'($signed(b.y));
		dz = longint'($signed(a.z)) - longint'($signed(b.z));
		return dx * dx + dy * dy + dz * dz;
	endfunction

	function automatic logic [63:0] floor_root(input logic [63:0] n);
		logic [63:0] root, trial;
		root = '0;
		for (int b = 27; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= n)
				root = trial;
		end
		return root;
	endfunction

	task automatic advance_route(input route_req_t rq, output route_report_t rp);
		logic [63:0] seg, d2;
		rp = '0;
		case (rq.cmd)
			CMD_APPEND: begin
				if (model_count >= MAX_POINTS_DEF) begin
					rp.status = STAT_FULL;
				end else begin
					// the first point of a route has no segment
					if (model_count > 0) begin
						seg = floor_root(sq_dist(rq.pos, stored_route[model_count-1]));
						model_len = (seg >= 64'(LEN_MAX) - model_len) ? 64'(LEN_MAX)
							: model_len + seg;
					end
					stored_route[model_count] = rq.pos;
					model_count++;
				end
			end
			CMD_CHECK: begin
				if (model_index >= model_count) begin
					rp.status = STAT_NONE;
				end else begin
					d2 = sq_dist(rq.pos, stored_route[model_index]);
					if (d2 < 64'(model_tol) * 64'(model_tol)) begin
						model_index++;
						rp.reached = 1'b1;
					end
				end
			end
			CMD_REWIND: begin
				model_index = 0;
			end
			CMD_CLEAR: begin
				model_count = 0;
				model_index = 0;
				model_len = '0;
			end
		endcase
		rp.index = IDX_W'(model_index);
		rp.count = IDX_W'(model_count);
		rp.length = model_len[LEN_W-1:0];
		if (model_index < model_count)
			rp.target = stored_route[model_index];
	endtask

	task automatic check_field(input string label, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want_v, got_v);
			mismatch_count++;
		end
	endtask

	function automatic point_t pt(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y, input logic signed [COORD_W-1:0] z);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		return p;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		int v;
		v = $urandom_range(0, 20000);
		case ($urandom_range(0, 5))
			0: return C_MAX;
			1: return C_MIN;
			2, 3: return COORD_W'($urandom);
			default: return COORD_W'(v - 10000);
		endcase
	endfunction

	function automatic logic signed [COORD_W-1:0] near_coord(
			input logic signed [COORD_W-1:0] c, input int spread);
		int off;
		off = $urandom_range(0, spread);
		if ($urandom_range(0, 1) == 1)
			off = -off;
		return c + COORD_W'(off);
	endfunction

	function automatic point_t near_point(input point_t p, input int spread);
		return pt(near_coord(p.x, spread), near_coord(p.y, spread), near_coord(p.z, spread));
	endfunction

	function automatic point_t rand_point();
		return pt(rand_coord(), rand_coord(), rand_coord());
	endfunction

	task automatic queue_req(input cmd_t c, input point_t p);
		route_req_t rq;
		rq.cmd = c;
		rq.pos = p;
		pending_reqs.insert(pending_reqs.size(), rq);
		planned++;
	endtask

	task automatic plan_directed();
		queue_req(CMD_CHECK, pt(24'sd5, 24'sd5, 24'sd5));            // empty route
		queue_req(CMD_REWIND, pt(C_MAX, C_MIN, -24'sd1));
		queue_req(CMD_APPEND, pt(24'sd0, 24'sd0, 24'sd0));
		queue_req(CMD_APPEND, pt(24'sd2560, 24'sd0, 24'sd0));
		queue_req(CMD_CHECK, pt(24'sd2560, 24'sd0, 24'sd0));         // on the radius, no advance
		queue_req(CMD_CHECK, pt(24'sd0, -24'sd2559, 24'sd0));
		queue_req(CMD_CHECK, pt(24'sd2560, 24'sd0, 24'sd1));
		queue_req(CMD_CHECK, pt(24'sd0, 24'sd0, 24'sd0));            // past the end
		queue_req(CMD_REWIND, pt(24'sd0, 24'sd0, 24'sd0));
		queue_req(CMD_APPEND, pt(C_MAX, C_MAX, C_MAX));
		queue_req(CMD_APPEND, pt(C_MIN, C_MIN, C_MIN));
		queue_req(CMD_APPEND, pt(C_MAX, C_MIN, C_MAX));
		queue_req(CMD_APPEND, pt(-24'sd1, -24'sd1, -24'sd1));
		queue_req(CMD_CHECK, pt(24'sd0, 24'sd0, 24'sd0));
		queue_req(CMD_CLEAR, pt(C_MIN, C_MAX, 24'sd0));
		queue_req(CMD_CHECK, pt(24'sd0, 24'sd0, 24'sd0));
		queue_req(CMD_APPEND, pt(C_MIN, 24'sd0, C_MAX));
		queue_req(CMD_APPEND, pt(24'sh555555, 24'shAAAAAA, 24'sh0F0F0F));
		queue_req(CMD_CHECK, pt(C_MIN, 24'sd0, C_MAX));
		queue_req(CMD_CHECK, pt(24'shAAAAAA, 24'sh555555, 24'shF0F0F0));
		queue_req(CMD_CLEAR, pt(24'sd0, 24'sd0, 24'sd0));
	endtask

	// fill the route past capacity, mostly corner to corner for long segments
	task automatic plan_full_route();
		queue_req(CMD_CLEAR, rand_point());
		for (int i = 0; i < MAX_POINTS_DEF + 2; i++) begin
			if (i % 4 == 3)
				queue_req(CMD_APPEND, rand_point());
			else if (i % 2 == 0)
				queue_req(CMD_APPEND, pt(C_MAX, C_MAX, C_MAX));
			else
				queue_req(CMD_APPEND, pt(C_MIN, C_MIN, C_MIN));
		end
		queue_req(CMD_CHECK, pt(C_MAX, C_MAX, C_MAX));
		queue_req(CMD_CHECK, rand_point());
		queue_req(CMD_REWIND, rand_point());
		queue_req(CMD_CLEAR, rand_point());
	endtask

	task automatic plan_random(input int amount);
		int goal, pts, spread;
		point_t p;
		goal = planned + amount;
		spread = int'(plan_tol / 2);
		while (planned < goal) begin
			if ($urandom_range(0, 7) == 0) begin
				queue_req(cmd_t'($urandom_range(0, 3)), pt(COORD_W'($urandom),
					COORD_W'($urandom), COORD_W'($urandom)));
			end else begin
				if ($urandom_range(0, 4) != 0) begin
					queue_req(CMD_CLEAR, rand_point());
					planned_route.delete();
				end
				pts = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
				repeat (pts) begin
					if (planned_route.size() > 0 && $urandom_range(0, 2) == 0)
						p = near_point(planned_route[$], 3000);
					else
						p = rand_point();
					queue_req(CMD_APPEND, p);
					if (planned_route.size() < MAX_POINTS_DEF)
						planned_route.insert(planned_route.size(), p);
				end
				queue_req(CMD_REWIND, rand_point());
				// walk the route: a few misses, then mostly a hit on each waypoint
				foreach (planned_route[k]) begin
					repeat ($urandom_range(0, 2))
						queue_req(CMD_CHECK, rand_point());
					case ($urandom_range(0, 9))
						0: queue_req(CMD_CHECK, pt(planned_route[k].x + COORD_W'(plan_tol),
							planned_route[k].y, planned_route[k].z));
						1: queue_req(CMD_CHECK, near_point(planned_route[k], 2 * spread + 1));
						default: queue_req(CMD_CHECK, near_point(planned_route[k], spread));
					endcase
					if ($urandom_range(0, 29) == 0)
						queue_req(CMD_REWIND, rand_point());
				end
				repeat ($urandom_range(0, 2))
					queue_req(CMD_CHECK, rand_point());
			end
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || start || reports_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_tolerance(input logic [TOL_W-1:0] value);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		plan_tol = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// request driver: bursts of back-to-back requests with random gaps
	always @(posedge clk or negedge arst_n) begin
		route_req_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() != 0) begin
				nxt = pending_reqs.pop_front();
				start <= 1'b1;
				command <= nxt.cmd;
				pos_x <= nxt.pos.x;
				pos_y <= nxt.pos.y;
				pos_z <= nxt.pos.z;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		route_req_t rq;
		route_report_t want;
		if (arst_n) begin
			if (cfg_we)
				model_tol = cfg_wdata;
			if (done) begin
				if (reports_due.size() == 0) begin
					$display("%0t: result with no request outstanding, expected none, actual status %0h",
						$time, status);
					mismatch_count++;
				end else begin
					want = reports_due.pop_front();
					check_field("status", 64'(want.status), 64'(status));
					check_field("reached", 64'(want.reached), 64'(reached));
					check_field("current_index", 64'(want.index), 64'(current_index));
					check_field("point_count", 64'(want.count), 64'(point_count));
					check_field("path_length", 64'(want.length), 64'(path_length));
					check_field("target_x", 64'(want.target.x), 64'(target_x));
					check_field("target_y", 64'(want.target.y), 64'(target_y));
					check_field("target_z", 64'(want.target.z), 64'(target_z));
				end
			end
			if (start && !busy) begin
				rq.cmd = cmd_t'(command);
				rq.pos = pt(pos_x, pos_y, pos_z);
				advance_route(rq, want);
				reports_due.insert(reports_due.size(), want);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout, no request or result for %0d cycles", $time, stall_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		plan_directed();
		plan_full_route();
		plan_random(350);
		load_tolerance('0);
		plan_random(250);
		load_tolerance({TOL_W{1'b1}});
		plan_random(250);
		load_tolerance(TOL_W'(1));
		plan_random(200);
		load_tolerance(TOL_W'($urandom_range(1, 4000)));
		plan_random(400);
		load_tolerance(TOL_RESET);
		plan_random(300);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/wrt_pkg.sv
hw/rtl/wrt_ram.sv
hw/rtl/wrt_dist.sv
hw/rtl/wrt_sqrt.sv
hw/rtl/waypoint_route_tracker.sv
bench/testbench.sv
